[design/grid_locator_to_latlon_unit_defines.svh]
// assertion macros for the grid locator decoder
// used by grid_locator_to_latlon_unit; expects clk and rst_n in scope
`ifndef GRID_LOCATOR_TO_LATLON_UNIT_DEFINES_SVH
`define GRID_LOCATOR_TO_LATLON_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GLL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gll assertion failed");

// next-cycle implication, checked out of reset
`define GLL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gll assertion failed");

`endif

[design/gll_pkg.sv]
// types, constants and helpers for the grid locator decoder
// no dependencies; used by gll_char_decode and grid_locator_to_latlon_unit
`default_nettype none

package gll_pkg;

    localparam int unsigned NUM_CHARS = 10;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_BAD_CHAR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CLASS_FIELD,
        CLASS_DIGIT,
        CLASS_SUB
    } char_class_t;

    typedef struct packed {
        logic [3:0] locator_length;
        logic [7:0] loc_char_0;
        logic [7:0] loc_char_1;
        logic [7:0] loc_char_2;
        logic [7:0] loc_char_3;
        logic [7:0] loc_char_4;
        logic [7:0] loc_char_5;
        logic [7:0] loc_char_6;
        logic [7:0] loc_char_7;
        logic [7:0] loc_char_8;
        logic [7:0] loc_char_9;
    } loc_word_t;

    typedef struct packed {
        logic signed [19:0] lat_units;
        logic signed [19:0] lon_units;
        status_t            status;
    } pos_word_t;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_FIVE    = 8'h35;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_L = 8'h4C;
    localparam logic [7:0] CHAR_UPPER_R = 8'h52;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP     = 8'h20;

    localparam logic [3:0] LEN_MIN = 4'd4;
    localparam logic [3:0] LEN_MAX = 4'd10;

    localparam logic [19:0] FIELD_WEIGHT  = 20'd57600;
    localparam logic [19:0] SQUARE_WEIGHT = 20'd5760;
    localparam logic [12:0] SUB_WEIGHT    = 13'd240;
    localparam logic [12:0] EXT_WEIGHT    = 13'd24;
    localparam logic [19:0] OFFSET_UNITS  = 20'd518400;

    localparam logic signed [19:0] UNITS_MIN = -20'sd518400;
    localparam logic signed [19:0] UNITS_MAX = 20'sd518399;

    function automatic char_class_t pos_class(input int unsigned pos);
        char_class_t cls;
        case (pos)
            0, 1:          cls = CLASS_FIELD;
            2, 3, 6, 7:    cls = CLASS_DIGIT;
            default:       cls = CLASS_SUB;
        endcase
        return cls;
    endfunction

    // square-centre padding for characters past the length
    function automatic logic [7:0] pad_char(input char_class_t cls);
        logic [7:0] pc;
        case (cls)
            CLASS_DIGIT: pc = CHAR_FIVE;
            CLASS_FIELD: pc = CHAR_UPPER_L;
            CLASS_SUB:   pc = CHAR_UPPER_L;
            default:     pc = CHAR_UPPER_L;
        endcase
        return pc;
    endfunction

endpackage

`default_nettype wire

[design/gll_char_decode.sv]
// decodes one locator character to its digit value and a legality flag
// depends on gll_pkg
`default_nettype none

module gll_char_decode (
    input  logic                 used,
    input  logic [7:0]           ch,
    input  gll_pkg::char_class_t char_class,
    output logic [4:0]           digit,
    output logic                 ok
);

    logic [7:0] eff;
    logic [7:0] fold;

    always_comb
    begin
        eff  = used ? ch : gll_pkg::pad_char(char_class);
        // case fold only matters for letter positions
        fold = (eff >= gll_pkg::CHAR_LOWER_A && eff <= gll_pkg::CHAR_LOWER_Z)
             ? eff - gll_pkg::CASE_GAP : eff;
        case (char_class)
            gll_pkg::CLASS_DIGIT:
            begin
                ok    = (eff >= gll_pkg::CHAR_ZERO) && (eff <= gll_pkg::CHAR_NINE);
                digit = 5'(eff - gll_pkg::CHAR_ZERO);
            end
            gll_pkg::CLASS_FIELD:
            begin
                ok    = (fold >= gll_pkg::CHAR_UPPER_A) && (fold <= gll_pkg::CHAR_UPPER_R);
                digit = 5'(fold - gll_pkg::CHAR_UPPER_A);
            end
            gll_pkg::CLASS_SUB:
            begin
                ok    = (fold >= gll_pkg::CHAR_UPPER_A) && (fold <= gll_pkg::CHAR_UPPER_X);
                digit = 5'(fold - gll_pkg::CHAR_UPPER_A);
            end
            default:
            begin
                ok    = (fold >= gll_pkg::CHAR_UPPER_A) && (fold <= gll_pkg::CHAR_UPPER_X);
                digit = 5'(fold - gll_pkg::CHAR_UPPER_A);
            end
        endcase
    end

endmodule

`default_nettype wire

[design/grid_locator_to_latlon_unit.sv]
// Grid locator decoder: an even-length 4..10 character locator in, latitude in
// 1/5760 degree and longitude in 1/2880 degree out, with a status code for bad
// length or bad characters. It takes one locator per cycle. Stage one decodes the
// ten characters, stage two forms the weighted partial sums, stage three adds them,
// removes the offset, zeroes an error result and holds the output word. Each stage
// stalls on its own, so a full pipeline keeps one word per cycle as long as the
// output side takes one per cycle. Depends on gll_pkg and gll_char_decode.
`default_nettype none

module grid_locator_to_latlon_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               loc_valid,
    output logic               loc_ready,
    input  gll_pkg::loc_word_t loc_word,
    output logic               pos_valid,
    input  logic               pos_ready,
    output gll_pkg::pos_word_t pos_word
);

    `include "grid_locator_to_latlon_unit_defines.svh"

    logic [7:0] chars [gll_pkg::NUM_CHARS];
    logic [4:0] digit_next [gll_pkg::NUM_CHARS];
    logic       ok_next [gll_pkg::NUM_CHARS];
    logic [gll_pkg::NUM_CHARS-1:0] ok_vec;

    assign chars[0] = loc_word.loc_char_0;
    assign chars[1] = loc_word.loc_char_1;
    assign chars[2] = loc_word.loc_char_2;
    assign chars[3] = loc_word.loc_char_3;
    assign chars[4] = loc_word.loc_char_4;
    assign chars[5] = loc_word.loc_char_5;
    assign chars[6] = loc_word.loc_char_6;
    assign chars[7] = loc_word.loc_char_7;
    assign chars[8] = loc_word.loc_char_8;
    assign chars[9] = loc_word.loc_char_9;

    for (genvar i = 0; i < gll_pkg::NUM_CHARS; i++)
    begin : g_char
        gll_char_decode u_dec (
            .used       (4'(i) < loc_word.locator_length),
            .ch         (chars[i]),
            .char_class (gll_pkg::pos_class(i)),
            .digit      (digit_next[i]),
            .ok         (ok_next[i])
        );
        assign ok_vec[i] = ok_next[i];
    end

    // stall control, one ready per stage
    logic ready1, ready2, ready3;
    logic v1_reg, v2_reg, v3_reg;

    assign ready3    = pos_ready || !v3_reg;
    assign ready2    = ready3 || !v2_reg;
    assign ready1    = ready2 || !v1_reg;
    assign loc_ready = ready1;

    // stage one: decoded digits and flags
    logic [4:0] digit_reg [gll_pkg::NUM_CHARS];
    logic       bad_len_reg, bad_char_reg;
    logic       bad_len_next, bad_char_next;

    assign bad_len_next = (loc_word.locator_length < gll_pkg::LEN_MIN)
                       || (loc_word.locator_length > gll_pkg::LEN_MAX)
                       || loc_word.locator_length[0];
    assign bad_char_next = !(&ok_vec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ready1)
        begin
            v1_reg <= loc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && loc_valid)
        begin
            digit_reg    <= digit_next;
            bad_len_reg  <= bad_len_next;
            bad_char_reg <= bad_char_next;
        end
    end

    // stage two: weighted partial sums, even positions longitude, odd latitude
    logic [19:0]          lat_hi_reg, lon_hi_reg, lat_hi_next, lon_hi_next;
    logic [12:0]          lat_lo_reg, lon_lo_reg, lat_lo_next, lon_lo_next;
    gll_pkg::status_t     status_reg, status_next;

    always_comb
    begin
        lon_hi_next = 20'(digit_reg[0]) * gll_pkg::FIELD_WEIGHT
                    + 20'(digit_reg[2]) * gll_pkg::SQUARE_WEIGHT;
        lat_hi_next = 20'(digit_reg[1]) * gll_pkg::FIELD_WEIGHT
                    + 20'(digit_reg[3]) * gll_pkg::SQUARE_WEIGHT;
        lon_lo_next = 13'(digit_reg[4]) * gll_pkg::SUB_WEIGHT
                    + 13'(digit_reg[6]) * gll_pkg::EXT_WEIGHT
                    + 13'(digit_reg[8]);
        lat_lo_next = 13'(digit_reg[5]) * gll_pkg::SUB_WEIGHT
                    + 13'(digit_reg[7]) * gll_pkg::EXT_WEIGHT
                    + 13'(digit_reg[9]);
        // length error wins over character error
        if (bad_len_reg)
            status_next = gll_pkg::STATUS_BAD_LEN;
        else if (bad_char_reg)
            status_next = gll_pkg::STATUS_BAD_CHAR;
        else
            status_next = gll_pkg::STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (ready2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            lat_hi_reg <= lat_hi_next;
            lon_hi_reg <= lon_hi_next;
            lat_lo_reg <= lat_lo_next;
            lon_lo_reg <= lon_lo_next;
            status_reg <= status_next;
        end
    end

    // stage three: final sum, south-west origin offset removed, error zeroing
    gll_pkg::pos_word_t out_reg, out_next;
    logic [19:0]        lat_sum, lon_sum;

    always_comb
    begin
        lat_sum = lat_hi_reg + 20'(lat_lo_reg) - gll_pkg::OFFSET_UNITS;
        lon_sum = lon_hi_reg + 20'(lon_lo_reg) - gll_pkg::OFFSET_UNITS;
        out_next.status = status_reg;
        if (status_reg == gll_pkg::STATUS_OK)
        begin
            out_next.lat_units = $signed(lat_sum);
            out_next.lon_units = $signed(lon_sum);
        end
        else
        begin
            out_next.lat_units = '0;
            out_next.lon_units = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (ready3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign pos_valid = v3_reg;
    assign pos_word  = out_reg;

    // an accepted word always lands in stage one
    `GLL_ASSERT_NEXT(a_accept_fills_s1, loc_valid && loc_ready, v1_reg)
    // a stalled middle stage keeps its word
    `GLL_ASSERT_NEXT(a_s2_holds, v2_reg && !ready3, v2_reg && $stable(status_reg) && $stable(lat_hi_reg))
    // a good result lies inside the coordinate range, an error result is zero
    `GLL_ASSERT_NOW(a_ok_range, pos_valid && pos_word.status == gll_pkg::STATUS_OK, (pos_word.lat_units >= gll_pkg::UNITS_MIN) && (pos_word.lat_units <= gll_pkg::UNITS_MAX) && (pos_word.lon_units >= gll_pkg::UNITS_MIN) && (pos_word.lon_units <= gll_pkg::UNITS_MAX))
    `GLL_ASSERT_NOW(a_err_zero, pos_valid && pos_word.status != gll_pkg::STATUS_OK, pos_word.lat_units == 20'sd0 && pos_word.lon_units == 20'sd0)

endmodule

`default_nettype wire
